@@ rtl/smmd_pkg.sv @@
// Shared types, constants and codes for the scope min/max decimator.
// Used by the divider, the top level and the checker; depends on nothing else.
package smmd_pkg;

  localparam int BUFFER_SIZE  = 2048;
  localparam int BUF_AW       = $clog2(BUFFER_SIZE);
  localparam int NUM_CHANNELS = 4;
  localparam int SAMPLE_BITS  = 16;

  localparam int OP_W       = 2;
  localparam int PIX_W      = 11;
  localparam int WIDTH_W    = 12;
  localparam int ACT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CHANNELS = 2'd1;

  localparam int DIV_Q_W   = 12;
  localparam int DIV_DEN_W = 12;
  localparam int DIV_NUM_W = DIV_DEN_W + DIV_Q_W - 1;
  localparam int DIV_CNT_W = $clog2(DIV_Q_W);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    sample_t          sample_ch0;
    sample_t          sample_ch1;
    sample_t          sample_ch2;
    sample_t          sample_ch3;
    logic [PIX_W-1:0] pixel_index;
  } in_item_t;

  typedef struct packed {
    sample_t pixel_min;
    sample_t pixel_max;
    logic    pixel_valid;
  } out_item_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ rtl/smmd_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; no package needed.
module smmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/smmd_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on smmd_pkg for widths and the request and response structs.
module smmd_div (
  input  logic               clk,
  input  logic               rst_n,
  input  smmd_pkg::div_req_t req,
  output smmd_pkg::div_rsp_t rsp
);
  import smmd_pkg::*;

  logic [DIV_NUM_W-1:0] rem_r, rem_nxt;
  logic [DIV_NUM_W-1:0] dsh_r, dsh_nxt;
  logic [DIV_Q_W-1:0]   q_r, q_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.num;
      dsh_nxt  = DIV_NUM_W'(req.den) << (DIV_Q_W - 1);
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= dsh_r) begin
        rem_nxt = rem_r - dsh_r;
        q_nxt   = {q_r[DIV_Q_W-2:0], 1'b1};
      end else begin
        q_nxt   = {q_r[DIV_Q_W-2:0], 1'b0};
      end
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIV_Q_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

@@ rtl/scope_min_max_decimator.sv @@
// Top level of the scope min/max decimator: sequencer, capture ring and output register.
// Depends on smmd_pkg, smmd_ram and smmd_div.
//
// Usage: items arrive on the in_ channel (valid/ready) and each is one of three operations;
// an item with any other code is taken and dropped. A write frame stores the
// largest-magnitude active channel sample, sign kept, in a 2048-entry ring and gives no
// result. A read names a display pixel and returns the minimum and maximum of the ring
// samples that fall on it, pixel 0 holding the newest. A read makes the two ceiling
// divisions in turn on the shared serial divider, then reads the samples on the pixel one
// by one through the single ring read port, then drains the last read and loads the
// result. A pixel at or beyond the display width answers with pixel_valid low. A clear
// sweeps the ring one entry a cycle with no result. in_ready is high only while the block
// is idle. The result sits in an output register until its transfer completes; a stalled
// receiver holds the next read at its last step. After reset the ring is zeroed by the
// same sweep before the first item is taken. The cfg_ channel is always ready; the user
// must see that it is written only while the block is idle; the block does not enforce it.
module scope_min_max_decimator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  smmd_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output smmd_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [smmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [smmd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import smmd_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_PEAK   = 3'd2;
  localparam logic [2:0] ST_DIV_LO = 3'd3;
  localparam logic [2:0] ST_DIV_HI = 3'd4;
  localparam logic [2:0] ST_WALK   = 3'd5;
  localparam logic [2:0] ST_DRAIN  = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  function automatic logic [SAMPLE_BITS:0] mag(input sample_t s);
    logic signed [SAMPLE_BITS:0] e;
    e = {s[SAMPLE_BITS-1], s};
    mag = e[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-e) : (SAMPLE_BITS+1)'(e);
  endfunction

  logic [2:0]           state_r, state_nxt;
  logic [BUF_AW-1:0]    wp_r, wp_nxt;
  logic [BUF_AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [WIDTH_W-1:0]   dw_r, dw_nxt;
  logic [ACT_W-1:0]     ac_r, ac_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 div_go_r, div_go_nxt;
  logic                 rd_pend_r, rd_pend_nxt;

  sample_t              smp_r [NUM_CHANNELS];
  sample_t              smp_nxt [NUM_CHANNELS];
  sample_t              peak_r, peak_nxt;
  logic [ACT_W-1:0]     ch_r, ch_nxt;
  logic [ACT_W-1:0]     n_r, n_nxt;
  logic [PIX_W-1:0]     p_r, p_nxt;
  logic [WIDTH_W-1:0]   w_r, w_nxt;
  logic [DIV_Q_W-1:0]   k_r, k_nxt;
  logic [DIV_Q_W-1:0]   k_end_r, k_end_nxt;
  logic [BUF_AW-1:0]    slot_r, slot_nxt;
  logic                 first_issue_r, first_issue_nxt;
  logic                 first_pend_r, first_pend_nxt;
  sample_t              lo_r, lo_nxt;
  sample_t              hi_r, hi_nxt;
  logic                 pv_r, pv_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic                 ram_we;
  logic [BUF_AW-1:0]    ram_waddr;
  sample_t              ram_wdata;
  logic [BUF_AW-1:0]    ram_raddr;
  sample_t              ram_rdata;

  div_req_t             div_req;
  div_rsp_t             div_rsp;
  logic [WIDTH_W-1:0]   w_eff;
  logic [DIV_NUM_W-1:0] num_lo;
  logic [DIV_NUM_W-1:0] num_hi;
  sample_t              cur_smp;

  smmd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (BUFFER_SIZE)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  smmd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign w_eff = (dw_r > WIDTH_W'(BUFFER_SIZE)) ? WIDTH_W'(BUFFER_SIZE) : dw_r;

  assign num_lo = {1'b0, p_r, {BUF_AW{1'b0}}} + DIV_NUM_W'(w_r - WIDTH_W'(1));
  assign num_hi = {(WIDTH_W'(p_r) + WIDTH_W'(1)), {BUF_AW{1'b0}}}
                + DIV_NUM_W'(w_r - WIDTH_W'(1));

  assign div_req.start = div_go_r;
  assign div_req.num   = (state_r == ST_DIV_HI) ? num_hi : num_lo;
  assign div_req.den   = w_r;

  assign cur_smp = smp_r[ch_r[1:0]];

  always_comb begin
    state_nxt       = state_r;
    wp_nxt          = wp_r;
    clr_cnt_nxt     = clr_cnt_r;
    dw_nxt          = dw_r;
    ac_nxt          = ac_r;
    out_valid_nxt   = out_valid_r;
    div_go_nxt      = 1'b0;
    rd_pend_nxt     = 1'b0;
    smp_nxt         = smp_r;
    peak_nxt        = peak_r;
    ch_nxt          = ch_r;
    n_nxt           = n_r;
    p_nxt           = p_r;
    w_nxt           = w_r;
    k_nxt           = k_r;
    k_end_nxt       = k_end_r;
    slot_nxt        = slot_r;
    first_issue_nxt = first_issue_r;
    first_pend_nxt  = 1'b0;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    pv_nxt          = pv_r;
    out_data_nxt    = out_data_r;
    ram_we          = 1'b0;
    ram_waddr       = wp_r;
    ram_wdata       = '0;
    ram_raddr       = slot_r;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_DISPLAY_WIDTH:   dw_nxt = cfg_data;
        CFG_ACTIVE_CHANNELS: ac_nxt = cfg_data[ACT_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Ring data returns in the cycle after its address; fold it into the running extremes.
    if (rd_pend_r) begin
      if (first_pend_r) begin
        lo_nxt = ram_rdata;
        hi_nxt = ram_rdata;
      end else begin
        if (ram_rdata < lo_r) begin
          lo_nxt = ram_rdata;
        end
        if (ram_rdata > hi_r) begin
          hi_nxt = ram_rdata;
        end
      end
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + BUF_AW'(1);
        if (clr_cnt_r == BUF_AW'(BUFFER_SIZE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.operation)
            OP_WRITE: begin
              smp_nxt[0] = in_data.sample_ch0;
              smp_nxt[1] = in_data.sample_ch1;
              smp_nxt[2] = in_data.sample_ch2;
              smp_nxt[3] = in_data.sample_ch3;
              peak_nxt   = '0;
              ch_nxt     = '0;
              n_nxt      = (ac_r > ACT_W'(NUM_CHANNELS)) ? ACT_W'(NUM_CHANNELS) : ac_r;
              state_nxt  = ST_PEAK;
            end
            OP_READ: begin
              p_nxt = in_data.pixel_index;
              w_nxt = w_eff;
              if ((w_eff != '0) && (WIDTH_W'(in_data.pixel_index) < w_eff)) begin
                pv_nxt     = 1'b1;
                div_go_nxt = 1'b1;
                state_nxt  = ST_DIV_LO;
              end else begin
                pv_nxt    = 1'b0;
                lo_nxt    = '0;
                hi_nxt    = '0;
                state_nxt = ST_OUT;
              end
            end
            OP_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      ST_PEAK: begin
        if (ch_r < n_r) begin
          if (mag(cur_smp) > mag(peak_r)) begin
            peak_nxt = cur_smp;
          end
          ch_nxt = ch_r + ACT_W'(1);
        end else begin
          ram_we    = 1'b1;
          ram_waddr = wp_r;
          ram_wdata = peak_r;
          wp_nxt    = wp_r + BUF_AW'(1);
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV_LO: begin
        if (div_rsp.done) begin
          k_nxt      = div_rsp.quot;
          div_go_nxt = 1'b1;
          state_nxt  = ST_DIV_HI;
        end
      end
      ST_DIV_HI: begin
        if (div_rsp.done) begin
          k_end_nxt       = div_rsp.quot;
          slot_nxt        = wp_r - BUF_AW'(1) - k_r[BUF_AW-1:0];
          first_issue_nxt = 1'b1;
          state_nxt       = ST_WALK;
        end
      end
      ST_WALK: begin
        ram_raddr       = slot_r;
        rd_pend_nxt     = 1'b1;
        first_pend_nxt  = first_issue_r;
        first_issue_nxt = 1'b0;
        slot_nxt        = slot_r - BUF_AW'(1);
        k_nxt           = k_r + DIV_Q_W'(1);
        if ((k_r + DIV_Q_W'(1)) == k_end_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.pixel_min   = lo_r;
          out_data_nxt.pixel_max   = hi_r;
          out_data_nxt.pixel_valid = pv_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      wp_r        <= '0;
      clr_cnt_r   <= '0;
      dw_r        <= WIDTH_W'(1024);
      ac_r        <= ACT_W'(1);
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      dw_r        <= dw_nxt;
      ac_r        <= ac_nxt;
      out_valid_r <= out_valid_nxt;
      div_go_r    <= div_go_nxt;
      rd_pend_r   <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp_r         <= smp_nxt;
    peak_r        <= peak_nxt;
    ch_r          <= ch_nxt;
    n_r           <= n_nxt;
    p_r           <= p_nxt;
    w_r           <= w_nxt;
    k_r           <= k_nxt;
    k_end_r       <= k_end_nxt;
    slot_r        <= slot_nxt;
    first_issue_r <= first_issue_nxt;
    first_pend_r  <= first_pend_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    pv_r          <= pv_nxt;
    out_data_r    <= out_data_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

@@ rtl/smmd_checker.sv @@
// Port-level checks for the scope min/max decimator, bound to its top level.
// Depends on smmd_pkg and on scope_min_max_decimator for the bind.
module smmd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input smmd_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input smmd_pkg::out_item_t out_data
);
  import smmd_pkg::*;

  // The ring is swept clear after reset, so no item is taken straight away.
  a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("input ready straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or vanished");

  // A result never appears in the cycle after a transfer on the input side.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared too early");

  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.operation == OP_WRITE ||
     in_data.operation == OP_READ || in_data.operation == OP_CLEAR)) |=> !in_ready)
    else $error("input ready while an item is in progress");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.pixel_valid) |->
      (out_data.pixel_min == '0 && out_data.pixel_max == '0))
    else $error("invalid pixel carries non-zero extremes");

endmodule

bind scope_min_max_decimator smmd_checker u_smmd_checker (.*);

@@ test/tb_scope_min_max_decimator.sv @@
// Self-checking testbench for scope_min_max_decimator: peak capture, pixel min/max reads,
// clears and register settings, checked against an in-bench model of the capture ring.
// Depends on smmd_pkg and the scope_min_max_decimator RTL.
`timescale 1ns / 1ps

module tb_scope_min_max_decimator;
  import smmd_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 2200;
  localparam int PHASES = 8;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DISPLAY_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sample_t ring_model [BUFFER_SIZE];
  logic [BUF_AW-1:0] next_slot = '0;
  logic [WIDTH_W-1:0] shadow_width = 12'd1024;
  logic [ACT_W-1:0] shadow_channels = 3'd1;

  in_item_t pending_items[$];
  out_item_t expected_pixels[$];
  int error_count = 0;
  int items_accepted = 0;
  int pixels_checked = 0;
  int settings_used = 1;
  bit steady = 1'b0;

  int phase_width [PHASES] = '{2048, 1, 4095, 0, 5, 37, 2047, 700};
  int phase_chan [PHASES] = '{4, 3, 7, 0, 2, 12'hA04, 1, 4};
  int phase_items [PHASES] = '{90, 50, 90, 50, 60, 80, 70, 70};

  scope_min_max_decimator uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < 50) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    error_count++;
  endtask

  function automatic sample_t frame_peak(input in_item_t it);
    sample_t ch [NUM_CHANNELS];
    int n;
    int peak;
    int s;
    ch[0] = it.sample_ch0;
    ch[1] = it.sample_ch1;
    ch[2] = it.sample_ch2;
    ch[3] = it.sample_ch3;
    n = int'(shadow_channels);
    if (n > NUM_CHANNELS) begin
      n = NUM_CHANNELS;
    end
    peak = 0;
    for (int c = 0; c < n; c++) begin
      s = ch[c];
      if ((s < 0 ? -s : s) > (peak < 0 ? -peak : peak)) begin
        peak = s;
      end
    end
    return sample_t'(peak);
  endfunction

  function automatic out_item_t pixel_extremes(input logic [PIX_W-1:0] pix);
    int w;
    int p;
    int k_lo;
    int k_end;
    int slot;
    sample_t v;
    sample_t lo;
    sample_t hi;
    out_item_t r;
    r = '0;
    p = int'(pix);
    w = int'(shadow_width);
    if (w > BUFFER_SIZE) begin
      w = BUFFER_SIZE;
    end
    if (w == 0 || p >= w) begin
      return r;
    end
    k_lo = (p * BUFFER_SIZE + w - 1) / w;
    k_end = ((p + 1) * BUFFER_SIZE + w - 1) / w;
    if (k_end > BUFFER_SIZE) begin
      k_end = BUFFER_SIZE;
    end
    lo = '0;
    hi = '0;
    for (int k = k_lo; k < k_end; k++) begin
      slot = (int'(next_slot) + 2 * BUFFER_SIZE - 1 - k) % BUFFER_SIZE;
      v = ring_model[slot];
      if (k == k_lo) begin
        lo = v;
        hi = v;
      end else begin
        if (v < lo) lo = v;
        if (v > hi) hi = v;
      end
    end
    r.pixel_min = lo;
    r.pixel_max = hi;
    r.pixel_valid = 1'b1;
    return r;
  endfunction

  task automatic advance_scope(input in_item_t it);
    case (it.operation)
      OP_WRITE: begin
        ring_model[next_slot] = frame_peak(it);
        next_slot = next_slot + 1'b1;
      end
      OP_READ: begin
        expected_pixels.push_back(pixel_extremes(it.pixel_index));
      end
      OP_CLEAR: begin
        foreach (ring_model[i]) ring_model[i] = '0;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : frame_driver
    logic take_next;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      take_next = !in_valid;
      if (in_valid && in_ready) begin
        advance_scope(pending_items.pop_front());
        items_accepted++;
        take_next = 1'b1;
      end
      if (take_next) begin
        if (pending_items.size() > 0 && (steady || $urandom_range(0, 99) >= 15)) begin
          in_valid <= 1'b1;
          in_data <= pending_items[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result with none pending: min %0d max %0d valid %0b",
                                    out_data.pixel_min, out_data.pixel_max,
                                    out_data.pixel_valid));
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.pixel_valid !== want.pixel_valid)
            report_mismatch($sformatf("pixel_valid %0b, expected %0b",
                                      out_data.pixel_valid, want.pixel_valid));
          if (out_data.pixel_min !== want.pixel_min)
            report_mismatch($sformatf("pixel_min %0d, expected %0d",
                                      out_data.pixel_min, want.pixel_min));
          if (out_data.pixel_max !== want.pixel_max)
            report_mismatch($sformatf("pixel_max %0d, expected %0d",
                                      out_data.pixel_max, want.pixel_max));
          pixels_checked++;
        end
      end
      out_ready <= steady || ($urandom_range(0, 99) >= 15);
    end
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_DISPLAY_WIDTH) begin
      shadow_width = val;
    end else begin
      shadow_channels = val[ACT_W-1:0];
    end
  endtask

  task automatic settle();
    while (pending_items.size() > 0 || expected_pixels.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_frame(input logic [OP_W-1:0] op, input int s0, input int s1,
                             input int s2, input int s3, input int pix);
    in_item_t it;
    it.operation = op;
    it.sample_ch0 = sample_t'(s0);
    it.sample_ch1 = sample_t'(s1);
    it.sample_ch2 = sample_t'(s2);
    it.sample_ch3 = sample_t'(s3);
    it.pixel_index = PIX_W'(pix);
    pending_items.push_back(it);
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(0, 11))
      0: return sample_t'(-32768);
      1: return sample_t'(32767);
      2: return sample_t'(0);
      3: return sample_t'(-1);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_item(input int w);
    in_item_t it;
    int r;
    int weff;
    int pix;
    it.sample_ch0 = random_sample();
    it.sample_ch1 = random_sample();
    it.sample_ch2 = random_sample();
    it.sample_ch3 = random_sample();
    if ($urandom_range(0, 7) == 0) begin
      it.sample_ch1 = -it.sample_ch0;
    end
    r = $urandom_range(0, 99);
    if (r < 54) it.operation = OP_WRITE;
    else if (r < 92) it.operation = OP_READ;
    else if (r < 94) it.operation = OP_CLEAR;
    else it.operation = OP_UNUSED;
    weff = (w > BUFFER_SIZE) ? BUFFER_SIZE : w;
    r = $urandom_range(0, 99);
    if (weff == 0 || r < 15) begin
      pix = $urandom_range(0, (1 << PIX_W) - 1);
    end else if (r < 30) begin
      pix = weff - 1 + $urandom_range(0, 2);
      if (pix > (1 << PIX_W) - 1) pix = (1 << PIX_W) - 1;
    end else begin
      pix = $urandom_range(0, (weff - 1) / 8);
    end
    it.pixel_index = PIX_W'(pix);
    return it;
  endfunction

  task automatic queue_random(input int count, input int w);
    in_item_t it;
    int made;
    made = 0;
    while (made < count) begin
      it = random_item(w);
      pending_items.push_back(it);
      if (it.operation != OP_UNUSED) made++;
    end
  endtask

  task automatic queue_directed();
    queue_frame(OP_WRITE, 0, 0, 0, 0, 0);
    queue_frame(OP_WRITE, 32767, -5, 3, 0, 0);
    queue_frame(OP_WRITE, -32768, 32767, 0, 0, 0);
    queue_frame(OP_WRITE, 5, -5, 0, 0, 0);
    queue_frame(OP_WRITE, -7, 7, 7, -7, 0);
    queue_frame(OP_WRITE, 1, -2, 3, -4, 0);
    queue_frame(OP_WRITE, 0, 0, 0, -32768, 0);
    for (int p = 0; p < 7; p++) begin
      queue_frame(OP_READ, 0, 0, 0, 0, p);
    end
    queue_frame(OP_READ, -1, -1, -1, -1, 2047);
    queue_frame(OP_UNUSED, -1, -1, -1, -1, 2047);
    queue_frame(OP_READ, 0, 0, 0, 0, 0);
    queue_frame(OP_CLEAR, 0, 0, 0, 0, 0);
    queue_frame(OP_READ, 0, 0, 0, 0, 0);
    queue_frame(OP_WRITE, 100, -200, 50, 0, 0);
    queue_frame(OP_READ, 0, 0, 0, 0, 0);
    queue_frame(OP_READ, 0, 0, 0, 0, 1);
  endtask

  initial begin
    foreach (ring_model[i]) ring_model[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings first, with idling on both sides.
    queue_random(40, 1024);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      steady = (ph == 0);
      write_register(CFG_DISPLAY_WIDTH, CFG_DATA_W'(phase_width[ph]));
      write_register(CFG_ACTIVE_CHANNELS, CFG_DATA_W'(phase_chan[ph]));
      settings_used++;
      if (ph == 0) begin
        queue_directed();
      end
      queue_random(phase_items[ph], phase_width[ph]);
      settle();
    end

    $display("%0d items transferred across %0d register settings", items_accepted,
             settings_used);
    $display("%0d pixel reads compared, %0d mismatches", pixels_checked, error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/smmd_pkg.sv
rtl/smmd_ram.sv
rtl/smmd_div.sv
rtl/scope_min_max_decimator.sv
rtl/smmd_checker.sv
test/tb_scope_min_max_decimator.sv
